// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks clocked on clk and disabled during rst; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FCT_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FCT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FCT_ASSERT_IMPL(name, ante, cons, msg)
`define FCT_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/fct_pkg.sv =====
// ----------------------------------------------------------------------------
// fct_pkg
// Types and fixed widths shared by the frustum cull tester.
// ----------------------------------------------------------------------------
package fct_pkg;

  // field widths
  localparam int COORD_W     = 32;
  localparam int NORMAL_W    = 16;
  localparam int RADIUS_W    = 31;
  localparam int SLOT_W      = 3;
  localparam int DEPTH_W     = 32;
  // normals are Q2.14, so products carry NORMAL_FRAC extra fraction bits
  localparam int NORMAL_FRAC = NORMAL_W - 2;
  // three products plus the shifted offset, with headroom
  localparam int DIST_W      = NORMAL_W + COORD_W + 2;
  localparam int SHIFT_W     = DIST_W - NORMAL_FRAC;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_POINT  = 2'd1,
    OP_SPHERE = 2'd2,
    OP_BOX    = 2'd3
  } op_t;

  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef logic signed [NORMAL_W-1:0] normal_t;
  typedef logic        [RADIUS_W-1:0] radius_t;
  typedef logic        [SLOT_W-1:0]   slot_t;
  typedef logic signed [DIST_W-1:0]   dist_t;
  typedef logic signed [DEPTH_W-1:0]  depth_t;

  localparam depth_t DEPTH_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};
  localparam depth_t DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};

  // one request as held in the input register
  typedef struct packed {
    op_t     operation;
    slot_t   plane_slot;
    coord_t  first_x;
    coord_t  first_y;
    coord_t  first_z;
    coord_t  second_x;
    coord_t  second_y;
    coord_t  second_z;
    coord_t  plane_offset;
    radius_t sphere_radius;
  } req_t;

  // control carried alongside the registered distances
  typedef struct packed {
    logic    valid;
    op_t     operation;
    radius_t sphere_radius;
  } ctl_t;

endpackage

// ===== hw/rtl/fct_req_if.sv =====
// ----------------------------------------------------------------------------
// fct_req_if
// Request channel: valid/ready handshake with the query or plane load fields.
// ----------------------------------------------------------------------------
interface fct_req_if;
  import fct_pkg::*;

  logic    valid;
  logic    ready;
  op_t     operation;
  slot_t   plane_slot;
  coord_t  first_x;
  coord_t  first_y;
  coord_t  first_z;
  coord_t  second_x;
  coord_t  second_y;
  coord_t  second_z;
  coord_t  plane_offset;
  radius_t sphere_radius;

  modport source (
    output valid, operation, plane_slot, first_x, first_y, first_z,
           second_x, second_y, second_z, plane_offset, sphere_radius,
    input  ready
  );

  modport sink (
    input  valid, operation, plane_slot, first_x, first_y, first_z,
           second_x, second_y, second_z, plane_offset, sphere_radius,
    output ready
  );
endinterface

// ===== hw/rtl/fct_res_if.sv =====
// ----------------------------------------------------------------------------
// fct_res_if
// Result channel: valid/ready handshake with the verdict and sphere depth.
// ----------------------------------------------------------------------------
interface fct_res_if;
  import fct_pkg::*;

  logic   valid;
  logic   ready;
  logic   inside_res;
  depth_t sphere_depth;

  modport source (
    output valid, inside_res, sphere_depth,
    input  ready
  );

  modport sink (
    input  valid, inside_res, sphere_depth,
    output ready
  );
endinterface

// ===== hw/rtl/frustum_cull_tester.sv =====
// ----------------------------------------------------------------------------
// frustum_cull_tester
// Fixed-point view frustum culling against a bank of clipping planes.
// ----------------------------------------------------------------------------
// Takes one request per clock and returns one result per request, in order.
// A request passes through three registers (input, plane distances, result).
// The only thing that holds the pipe is the result register waiting on
// res.ready, and then the whole pipe stalls together. All planes are
// evaluated side by side, one multiplier per normal component per plane. A
// plane load is written as it leaves the input register and is seen by the
// very next request; its result is inside_res = 0, sphere_depth = 0. All
// planes are zero after reset.
module frustum_cull_tester #(
  parameter int PLANE_COUNT = 6
) (
  input  logic  clk,
  input  logic  rst,
  fct_req_if.sink   req,
  fct_res_if.source res
);
  import fct_pkg::*;

  `include "assert_macros.svh"

  logic    advance;
  logic    s0_valid;
  req_t    s0_req;
  logic    plane_we;
  normal_t normal_x [PLANE_COUNT];
  normal_t normal_y [PLANE_COUNT];
  normal_t normal_z [PLANE_COUNT];
  coord_t  offset   [PLANE_COUNT];
  ctl_t    s1_ctl;
  dist_t   s1_dist  [PLANE_COUNT];

  // pipe moves whenever the result slot is empty or being taken; no requests in reset
  assign advance   = !res.valid || res.ready;
  assign req.ready = advance && !rst;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (advance) begin
      s0_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && req.valid) begin
      s0_req <= '{operation:     req.operation,
                  plane_slot:    req.plane_slot,
                  first_x:       req.first_x,
                  first_y:       req.first_y,
                  first_z:       req.first_z,
                  second_x:      req.second_x,
                  second_y:      req.second_y,
                  second_z:      req.second_z,
                  plane_offset:  req.plane_offset,
                  sphere_radius: req.sphere_radius};
    end
  end

  // plane load commits as the request leaves the input register
  assign plane_we = s0_valid && advance && (s0_req.operation == OP_LOAD);

  fct_plane_bank #(
    .PLANE_COUNT (PLANE_COUNT)
  ) u_bank (
    .clk       (clk),
    .rst       (rst),
    .we        (plane_we),
    .wr_slot   (s0_req.plane_slot),
    .wr_nx     ($signed(s0_req.first_x[NORMAL_W-1:0])),
    .wr_ny     ($signed(s0_req.first_y[NORMAL_W-1:0])),
    .wr_nz     ($signed(s0_req.first_z[NORMAL_W-1:0])),
    .wr_offset (s0_req.plane_offset),
    .normal_x  (normal_x),
    .normal_y  (normal_y),
    .normal_z  (normal_z),
    .offset    (offset)
  );

  fct_dist_stage #(
    .PLANE_COUNT (PLANE_COUNT)
  ) u_dist (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .s0_valid (s0_valid),
    .s0_req   (s0_req),
    .normal_x (normal_x),
    .normal_y (normal_y),
    .normal_z (normal_z),
    .offset   (offset),
    .s1_ctl   (s1_ctl),
    .s1_dist  (s1_dist)
  );

  fct_verdict #(
    .PLANE_COUNT (PLANE_COUNT)
  ) u_verdict (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .s1_ctl    (s1_ctl),
    .s1_dist   (s1_dist),
    .res_valid (res.valid),
    .passed    (res.inside_res),
    .depth     (res.sphere_depth)
  );

  // checks
  `FCT_ASSERT_NEXT(a_s0_to_s1, advance && s0_valid, s1_ctl.valid, "request lost between stages")
  `FCT_ASSERT_NEXT(a_s0_hold, !advance, $stable(s0_req) && $stable(s0_valid), "input register moved while stalled")
  `FCT_ASSERT_NEXT(a_load_not_inside, advance && s1_ctl.valid && (s1_ctl.operation == OP_LOAD), res.valid && !res.inside_res, "plane load reported inside")
  `FCT_ASSERT_IMPL(a_culled_zero_depth, res.valid && !res.inside_res, res.sphere_depth == '0, "culled result carries a depth")

endmodule

// ===== hw/rtl/fct_plane_bank.sv =====
// ----------------------------------------------------------------------------
// fct_plane_bank
// Plane register file: one normal and offset per slot, written by load
// requests, all planes visible in parallel to the distance stage.
// ----------------------------------------------------------------------------
module fct_plane_bank #(
  parameter int PLANE_COUNT = 6
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            we,
  input  fct_pkg::slot_t  wr_slot,
  input  fct_pkg::normal_t wr_nx,
  input  fct_pkg::normal_t wr_ny,
  input  fct_pkg::normal_t wr_nz,
  input  fct_pkg::coord_t wr_offset,
  output fct_pkg::normal_t normal_x [PLANE_COUNT],
  output fct_pkg::normal_t normal_y [PLANE_COUNT],
  output fct_pkg::normal_t normal_z [PLANE_COUNT],
  output fct_pkg::coord_t offset [PLANE_COUNT]
);
  import fct_pkg::*;

  // slot decode; a slot past the last plane matches nothing
  always_ff @(posedge clk) begin
    for (int p = 0; p < PLANE_COUNT; p++) begin
      if (rst) begin
        normal_x[p] <= '0;
        normal_y[p] <= '0;
        normal_z[p] <= '0;
        offset[p]   <= '0;
      end else if (we && (wr_slot == SLOT_W'(p))) begin
        normal_x[p] <= wr_nx;
        normal_y[p] <= wr_ny;
        normal_z[p] <= wr_nz;
        offset[p]   <= wr_offset;
      end
    end
  end

endmodule

// ===== hw/rtl/fct_dist_stage.sv =====
// ----------------------------------------------------------------------------
// fct_dist_stage
// Signed plane distances for every plane at once: corner select for boxes,
// three products and the offset term, registered per plane.
// ----------------------------------------------------------------------------
module fct_dist_stage #(
  parameter int PLANE_COUNT = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             s0_valid,
  input  fct_pkg::req_t    s0_req,
  input  fct_pkg::normal_t normal_x [PLANE_COUNT],
  input  fct_pkg::normal_t normal_y [PLANE_COUNT],
  input  fct_pkg::normal_t normal_z [PLANE_COUNT],
  input  fct_pkg::coord_t  offset [PLANE_COUNT],
  output fct_pkg::ctl_t    s1_ctl,
  output fct_pkg::dist_t   s1_dist [PLANE_COUNT]
);
  import fct_pkg::*;

  logic    s1_valid;
  op_t     s1_op;
  radius_t s1_radius;
  dist_t   dist_next [PLANE_COUNT];

  // per-plane distance in Q.30; box queries use the corner farthest along n
  always_comb begin
    for (int p = 0; p < PLANE_COUNT; p++) begin
      coord_t cx;
      coord_t cy;
      coord_t cz;
      logic   box;
      box = (s0_req.operation == OP_BOX);
      cx  = (box && (normal_x[p] > 0)) ? s0_req.second_x : s0_req.first_x;
      cy  = (box && (normal_y[p] > 0)) ? s0_req.second_y : s0_req.first_y;
      cz  = (box && (normal_z[p] > 0)) ? s0_req.second_z : s0_req.first_z;
      dist_next[p] = DIST_W'(normal_x[p]) * DIST_W'(cx)
                   + DIST_W'(normal_y[p]) * DIST_W'(cy)
                   + DIST_W'(normal_z[p]) * DIST_W'(cz)
                   + (DIST_W'(offset[p]) <<< NORMAL_FRAC);
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= s0_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_op     <= s0_req.operation;
      s1_radius <= s0_req.sphere_radius;
      s1_dist   <= dist_next;
    end
  end

  assign s1_ctl = '{valid: s1_valid, operation: s1_op, sphere_radius: s1_radius};

endmodule

// ===== hw/rtl/fct_verdict.sv =====
// ----------------------------------------------------------------------------
// fct_verdict
// Per-query pass test over all plane distances, sphere depth with floor
// rounding and saturation, and the result register.
// ----------------------------------------------------------------------------
module fct_verdict #(
  parameter int PLANE_COUNT = 6
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  fct_pkg::ctl_t   s1_ctl,
  input  fct_pkg::dist_t  s1_dist [PLANE_COUNT],
  output logic            res_valid,
  output logic            passed,
  output fct_pkg::depth_t depth
);
  import fct_pkg::*;

  dist_t                    rs_ext;
  dist_t                    neg_rs;
  logic                     pass;
  dist_t                    depth_sum;
  logic [SHIFT_W-1:0]       depth_shift;
  logic [SHIFT_W-DEPTH_W:0] depth_hi;
  depth_t                   depth_sat;

  // every plane must pass; a load never does
  always_comb begin
    rs_ext = DIST_W'({s1_ctl.sphere_radius, {NORMAL_FRAC{1'b0}}});
    neg_rs = -rs_ext;
    pass   = 1'b1;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      case (s1_ctl.operation)
        OP_POINT:  if (s1_dist[p] <= 0)      pass = 1'b0;
        OP_SPHERE: if (s1_dist[p] <= neg_rs) pass = 1'b0;
        OP_BOX:    if (s1_dist[p] < 0)       pass = 1'b0;
        default:   pass = 1'b0;
      endcase
    end
  end

  // last plane's distance plus radius, back to Q16.16 and clamped
  always_comb begin
    depth_sum   = s1_dist[PLANE_COUNT-1] + rs_ext;
    depth_shift = depth_sum[DIST_W-1:NORMAL_FRAC];
    depth_hi    = depth_shift[SHIFT_W-1:DEPTH_W-1];
    if ((&depth_hi) || !(|depth_hi)) begin
      depth_sat = depth_shift[DEPTH_W-1:0];
    end else if (depth_shift[SHIFT_W-1]) begin
      depth_sat = DEPTH_MIN;
    end else begin
      depth_sat = DEPTH_MAX;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_ctl.valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      passed <= pass;
      depth  <= (pass && (s1_ctl.operation == OP_SPHERE)) ? depth_sat : '0;
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the frustum cull tester. It keeps its own copy of
// the plane bank and works out each verdict when a request is accepted. The
// random part loads well-formed frustums and sends queries near the origin,
// mixed with phases of unconstrained requests. Both channels idle at random,
// and the result side holds off once for a long stretch to fill the pipe.
// ----------------------------------------------------------------------------
module tb;
  import fct_pkg::*;

  localparam int      PLANES     = 6;
  localparam int      ITEMS      = 550;
  localparam int      LATENCY    = 3;
  localparam int      MAX_IDLE   = 14;
  localparam int      HOLD_AT    = 180;
  localparam int      HOLD_OFF   = 300;
  localparam coord_t  ONE        = 32'sh0001_0000;
  localparam coord_t  COORD_MAX  = 32'sh7FFF_FFFF;
  localparam coord_t  COORD_MIN  = 32'sh8000_0000;
  localparam radius_t RADIUS_MAX = '1;

  // plane bank copy, verdict prediction and in-order comparison
  class cull_checker;
    typedef struct {
      logic   inside_res;
      depth_t sphere_depth;
    } verdict_t;

    normal_t  nx_bank[PLANES];
    normal_t  ny_bank[PLANES];
    normal_t  nz_bank[PLANES];
    coord_t   offset_bank[PLANES];
    verdict_t verdicts_due[$];
    int       mismatches;

    function new();
      foreach (nx_bank[p]) begin
        nx_bank[p]     = '0;
        ny_bank[p]     = '0;
        nz_bank[p]     = '0;
        offset_bank[p] = '0;
      end
      mismatches = 0;
    endfunction

    // signed distance in Q.30; exact in 64 bits at these widths
    function longint plane_distance(int p, longint x, longint y, longint z);
      return longint'(nx_bank[p]) * x + longint'(ny_bank[p]) * y
           + longint'(nz_bank[p]) * z + (longint'(offset_bank[p]) <<< NORMAL_FRAC);
    endfunction

    // called on every accepted request
    function void record_request(req_t r);
      verdict_t v;
      longint   ax, ay, az, bx, by, bz, rs, d, s;
      bit       clear;
      int       p;
      v.inside_res   = 1'b0;
      v.sphere_depth = '0;
      if (r.operation == OP_LOAD) begin
        // slots past the bank are dropped
        if (r.plane_slot < PLANES) begin
          nx_bank[r.plane_slot]     = normal_t'(r.first_x[NORMAL_W-1:0]);
          ny_bank[r.plane_slot]     = normal_t'(r.first_y[NORMAL_W-1:0]);
          nz_bank[r.plane_slot]     = normal_t'(r.first_z[NORMAL_W-1:0]);
          offset_bank[r.plane_slot] = r.plane_offset;
        end
      end else begin
        ax    = longint'(r.first_x);
        ay    = longint'(r.first_y);
        az    = longint'(r.first_z);
        bx    = longint'(r.second_x);
        by    = longint'(r.second_y);
        bz    = longint'(r.second_z);
        rs    = longint'(r.sphere_radius) <<< NORMAL_FRAC;
        clear = 1'b1;
        d     = 0;
        for (p = 0; p < PLANES && clear; p++) begin
          case (r.operation)
            OP_POINT: begin
              d     = plane_distance(p, ax, ay, az);
              clear = (d > 0);
            end
            OP_SPHERE: begin
              d     = plane_distance(p, ax, ay, az);
              clear = (d > -rs);
            end
            default: begin
              // farthest corner along the normal; zero component takes minimum
              d = plane_distance(p, (nx_bank[p] > 0) ? bx : ax,
                                    (ny_bank[p] > 0) ? by : ay,
                                    (nz_bank[p] > 0) ? bz : az);
              clear = (d >= 0);
            end
          endcase
        end
        if (clear) begin
          v.inside_res = 1'b1;
          if (r.operation == OP_SPHERE) begin
            // floor back to Q16.16, then clamp
            s = (d + rs) >>> NORMAL_FRAC;
            if (s > longint'(DEPTH_MAX))
              v.sphere_depth = DEPTH_MAX;
            else if (s < longint'(DEPTH_MIN))
              v.sphere_depth = DEPTH_MIN;
            else
              v.sphere_depth = depth_t'(s);
          end
        end
      end
      verdicts_due.push_back(v);
    endfunction

    // called on every accepted result
    function void check_verdict(logic inside_res, depth_t sphere_depth);
      verdict_t v;
      if (verdicts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no request outstanding: inside_res=%0b depth=%0d",
                   $realtime, inside_res, sphere_depth);
        return;
      end
      v = verdicts_due.pop_front();
      if (v.inside_res !== inside_res || v.sphere_depth !== sphere_depth) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: inside_res exp %0b got %0b, sphere_depth exp %0d got %0d",
                   $realtime, v.inside_res, inside_res, v.sphere_depth, sphere_depth);
      end
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  fct_req_if req_ch ();
  fct_res_if res_ch ();

  frustum_cull_tester #(
    .PLANE_COUNT (PLANES)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  cull_checker verdicts;
  int          sent_count;
  int          results_seen;
  bit          send_idles;
  bit          take_idles;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // every field random, any operation and any slot
  function automatic req_t wild_request();
    req_t r;
    r.operation     = op_t'($urandom_range(0, 3));
    r.plane_slot    = slot_t'($urandom_range(0, 7));
    r.first_x       = $urandom();
    r.first_y       = $urandom();
    r.first_z       = $urandom();
    r.second_x      = $urandom();
    r.second_y      = $urandom();
    r.second_z      = $urandom();
    r.plane_offset  = $urandom();
    r.sphere_radius = radius_t'($urandom());
    return r;
  endfunction

  function automatic req_t load_plane(int slot, coord_t nx, coord_t ny, coord_t nz,
                                      coord_t offset);
    req_t r;
    r              = wild_request();
    r.operation    = OP_LOAD;
    r.plane_slot   = slot_t'(slot);
    r.first_x      = nx;
    r.first_y      = ny;
    r.first_z      = nz;
    r.plane_offset = offset;
    return r;
  endfunction

  function automatic req_t query(op_t op, coord_t ax, coord_t ay, coord_t az,
                                 coord_t bx, coord_t by, coord_t bz, radius_t rad);
    req_t r;
    r               = wild_request();
    r.operation     = op;
    r.first_x       = ax;
    r.first_y       = ay;
    r.first_z       = az;
    r.second_x      = bx;
    r.second_y      = by;
    r.second_z      = bz;
    r.sphere_radius = rad;
    return r;
  endfunction

  // roughly axis-aligned plane with jitter; the pair on each axis faces inward
  function automatic req_t frustum_plane(int slot);
    int     axis;
    int     lead;
    int     n[3];
    coord_t w[3];
    axis = slot / 2;
    for (int k = 0; k < 3; k++) begin
      if (k == axis) begin
        lead = 16384 + int'($urandom_range(0, 4096)) - 2048;
        n[k] = (slot % 2) ? -lead : lead;
      end else begin
        n[k] = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 6000)) - 3000;
      end
      // upper half is junk, only the low bits are a normal
      w[k] = coord_t'({16'($urandom()), 16'(n[k])});
    end
    return load_plane(slot, w[0], w[1], w[2], coord_t'($urandom_range(0, 1 << 24)));
  endfunction

  function automatic coord_t near_coord();
    return coord_t'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
  endfunction

  // point, sphere or box around the origin, now and then with minimum above maximum
  function automatic req_t near_query();
    req_t   r;
    coord_t lo[3];
    coord_t hi[3];
    int     ext;
    r           = wild_request();
    r.operation = op_t'($urandom_range(1, 3));
    for (int k = 0; k < 3; k++) begin
      lo[k] = near_coord();
      ext   = $urandom_range(0, 1 << 23);
      hi[k] = ($urandom_range(0, 15) == 0) ? lo[k] - ext : lo[k] + ext;
    end
    r.first_x  = lo[0];
    r.first_y  = lo[1];
    r.first_z  = lo[2];
    r.second_x = hi[0];
    r.second_y = hi[1];
    r.second_z = hi[2];
    case ($urandom_range(0, 9))
      0:       ;
      1:       r.sphere_radius = '0;
      default: r.sphere_radius = radius_t'($urandom_range(0, 1 << 23));
    endcase
    return r;
  endfunction

  // offer one request after a random gap and wait for it to be taken
  task automatic offer_request(req_t r);
    int gap;
    if (sent_count % 32 == 0)
      send_idles = ($urandom_range(0, 2) != 0);
    gap = send_idles ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.operation     <= r.operation;
    req_ch.plane_slot    <= r.plane_slot;
    req_ch.first_x       <= r.first_x;
    req_ch.first_y       <= r.first_y;
    req_ch.first_z       <= r.first_z;
    req_ch.second_x      <= r.second_x;
    req_ch.second_y      <= r.second_y;
    req_ch.second_z      <= r.second_z;
    req_ch.plane_offset  <= r.plane_offset;
    req_ch.sphere_radius <= r.sphere_radius;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    verdicts.record_request(r);
    sent_count++;
  endtask

  // result side: random stalls, one long hold-off to back the pipe up
  task automatic take_results();
    int stall;
    forever begin
      if (results_seen % 32 == 0)
        take_idles = ($urandom_range(0, 2) != 0);
      stall = take_idles ? $urandom_range(0, MAX_IDLE) : 0;
      if (results_seen == HOLD_AT)
        stall = HOLD_OFF;
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
      verdicts.check_verdict(res_ch.inside_res, res_ch.sphere_depth);
      results_seen++;
    end
  endtask

  initial begin
    req_t r;
    int   n;
    bit   planes_tidy;
    verdicts     = new();
    sent_count   = 0;
    results_seen = 0;
    send_idles   = 1'b1;
    take_idles   = 1'b1;
    planes_tidy  = 1'b0;

    rst                  <= 1'b1;
    req_ch.valid         <= 1'b0;
    req_ch.operation     <= OP_LOAD;
    req_ch.plane_slot    <= '0;
    req_ch.first_x       <= '0;
    req_ch.first_y       <= '0;
    req_ch.first_z       <= '0;
    req_ch.second_x      <= '0;
    req_ch.second_y      <= '0;
    req_ch.second_z      <= '0;
    req_ch.plane_offset  <= '0;
    req_ch.sphere_radius <= '0;
    res_ch.ready         <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    fork
      take_results();
    join_none

    // zero planes after reset: point on every plane, spheres at zero and full radius, a full-range box
    offer_request(query(OP_POINT, 0, 0, 0, 0, 0, 0, '0));
    offer_request(query(OP_SPHERE, 0, 0, 0, 0, 0, 0, '0));
    offer_request(query(OP_SPHERE, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0, RADIUS_MAX));
    offer_request(query(OP_BOX, COORD_MIN, COORD_MIN, COORD_MIN,
                        COORD_MAX, COORD_MAX, COORD_MAX, '0));

    // box of half-width ten in x and y, about -5 to 10 in z, junk in the upper normal bits, extreme normals on z
    offer_request(load_plane(0, 32'shDEAD_4000, 0, 0, 10 * ONE));
    offer_request(load_plane(1, -16384, 0, 0, 10 * ONE));
    offer_request(load_plane(2, 0, 16384, 0, 10 * ONE));
    offer_request(load_plane(3, 0, -16384, 0, 10 * ONE));
    offer_request(load_plane(4, 0, 0, 32'sh0000_7FFF, 10 * ONE));
    offer_request(load_plane(5, 0, 0, 32'sh1234_8000, 20 * ONE));

    // loads to slots past the bank
    offer_request(load_plane(6, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
    offer_request(load_plane(7, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));

    // points: centre, exactly on a plane, one step inside, far corners
    offer_request(query(OP_POINT, 0, 0, 0, 0, 0, 0, '0));
    offer_request(query(OP_POINT, 10 * ONE, 0, 0, 0, 0, 0, '0));
    offer_request(query(OP_POINT, 10 * ONE - 1, 0, 0, 0, 0, 0, '0));
    offer_request(query(OP_POINT, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0, '0));
    offer_request(query(OP_POINT, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0, '0));

    // spheres: touching at minus the radius, one step clear, clamped depth
    offer_request(query(OP_SPHERE, 11 * ONE, 0, 0, 0, 0, 0, radius_t'(ONE)));
    offer_request(query(OP_SPHERE, 11 * ONE, 0, 0, 0, 0, 0, radius_t'(ONE + 1)));
    offer_request(query(OP_SPHERE, 0, 0, 0, 0, 0, 0, RADIUS_MAX));

    // boxes: inside, minimum above maximum, straddling a plane, outside
    offer_request(query(OP_BOX, -5 * ONE, -5 * ONE, -5 * ONE, 5 * ONE, 5 * ONE, 5 * ONE, '0));
    offer_request(query(OP_BOX, 20 * ONE, 20 * ONE, 20 * ONE,
                        -20 * ONE, -20 * ONE, -20 * ONE, '0));
    offer_request(query(OP_BOX, -15 * ONE, -ONE, -ONE, 0, ONE, ONE, '0));
    offer_request(query(OP_BOX, 30 * ONE, 30 * ONE, 30 * ONE,
                        40 * ONE, 40 * ONE, 40 * ONE, '0));

    // random phases: mostly tidy frustums with nearby queries, some noise
    while (sent_count < ITEMS) begin
      if ($urandom_range(0, 3) != 0) begin
        for (int p = 0; p < PLANES; p++)
          if (!planes_tidy || $urandom_range(0, 1) == 1)
            offer_request(frustum_plane(p));
        planes_tidy = 1'b1;
        if ($urandom_range(0, 4) == 0) begin
          r            = wild_request();
          r.operation  = OP_LOAD;
          r.plane_slot = slot_t'($urandom_range(PLANES, 7));
          offer_request(r);
        end
        n = $urandom_range(10, 40);
        repeat (n) offer_request(near_query());
      end else begin
        planes_tidy = 1'b0;
        n = $urandom_range(4, 16);
        repeat (n) offer_request(wild_request());
      end
    end
    req_ch.valid <= 1'b0;

    // drain, then wait for anything stray
    while (verdicts.pending() != 0) @(posedge clk);
    repeat (4 * LATENCY) @(posedge clk);
    if (verdicts.mismatches == 0 && verdicts.pending() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
